### design/pwad_pkg.sv
// Package for the pulse width autobaud detector: codes, register defaults,
// microcode control word and the microcode program table.
// No dependencies.
`timescale 1ns / 1ps

package pwad_pkg;

    localparam int OPCODE_W  = 2;
    localparam int PULSE_W   = 16;
    localparam int OUTCOME_W = 4;
    localparam int BIN_W     = 5;
    localparam int DIV_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int CNT_W     = 16;
    localparam int ITER_W    = 8;
    localparam int PC_W      = 5;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    localparam logic [OPCODE_W-1:0] OP_PULSE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_START = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_ABORT = 2'd2;

    localparam logic [OUTCOME_W-1:0] OC_IGNORED   = 4'd0;
    localparam logic [OUTCOME_W-1:0] OC_REJECTED  = 4'd1;
    localparam logic [OUTCOME_W-1:0] OC_SHORTEST  = 4'd2;
    localparam logic [OUTCOME_W-1:0] OC_MATCHED   = 4'd3;
    localparam logic [OUTCOME_W-1:0] OC_UNMATCHED = 4'd4;
    localparam logic [OUTCOME_W-1:0] OC_STARTED   = 4'd5;
    localparam logic [OUTCOME_W-1:0] OC_ABORTED   = 4'd6;
    localparam logic [OUTCOME_W-1:0] OC_SUCCESS   = 4'd7;
    localparam logic [OUTCOME_W-1:0] OC_FAIL      = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMATCH_LIM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIM   = 3'd4;

    localparam logic [PULSE_W-1:0] RST_MIN_WIDTH   = 16'd53;
    localparam logic [PULSE_W-1:0] RST_MAX_WIDTH   = 16'd40000;
    localparam logic [CNT_W-1:0]   RST_COUNT_LIM   = 16'd512;
    localparam logic [CNT_W-1:0]   RST_UNMATCH_LIM = 16'd112;
    localparam logic [ITER_W-1:0]  RST_ITER_LIM    = 8'd16;

    // micro-ops
    localparam logic [3:0] UOP_NOP            = 4'd0;
    localparam logic [3:0] UOP_FETCH          = 4'd1;
    localparam logic [3:0] UOP_RETRY          = 4'd2;
    localparam logic [3:0] UOP_INC_TOTAL      = 4'd3;
    localparam logic [3:0] UOP_LOAD_ACC       = 4'd4;
    localparam logic [3:0] UOP_STEP_ACC       = 4'd5;
    localparam logic [3:0] UOP_EMIT           = 4'd6;
    localparam logic [3:0] UOP_EMIT_START     = 4'd7;
    localparam logic [3:0] UOP_EMIT_ABORT     = 4'd8;
    localparam logic [3:0] UOP_EMIT_SUCCESS   = 4'd9;
    localparam logic [3:0] UOP_EMIT_FAIL      = 4'd10;
    localparam logic [3:0] UOP_EMIT_SHORT     = 4'd11;
    localparam logic [3:0] UOP_EMIT_UNMATCHED = 4'd12;

    // jump conditions
    localparam logic [3:0] CND_NEVER     = 4'd0;
    localparam logic [3:0] CND_ALWAYS    = 4'd1;
    localparam logic [3:0] CND_NO_INPUT  = 4'd2;
    localparam logic [3:0] CND_OP_START  = 4'd3;
    localparam logic [3:0] CND_OP_ABORT  = 4'd4;
    localparam logic [3:0] CND_NOT_RUN   = 4'd5;
    localparam logic [3:0] CND_NO_DECIDE = 4'd6;
    localparam logic [3:0] CND_UNM_OK    = 4'd7;
    localparam logic [3:0] CND_ATT_LE1   = 4'd8;
    localparam logic [3:0] CND_OUT_RANGE = 4'd9;
    localparam logic [3:0] CND_BELOW_LOW = 4'd10;
    localparam logic [3:0] CND_IN_WIN    = 4'd11;
    localparam logic [3:0] CND_MORE_BINS = 4'd12;

    // program addresses
    localparam logic [PC_W-1:0] A_FETCH    = 5'd0;
    localparam logic [PC_W-1:0] A_VALID    = 5'd8;
    localparam logic [PC_W-1:0] A_LOOP     = 5'd11;
    localparam logic [PC_W-1:0] A_START    = 5'd14;
    localparam logic [PC_W-1:0] A_ABORT    = 5'd15;
    localparam logic [PC_W-1:0] A_IGNORE   = 5'd16;
    localparam logic [PC_W-1:0] A_SUCCESS  = 5'd17;
    localparam logic [PC_W-1:0] A_FAIL     = 5'd18;
    localparam logic [PC_W-1:0] A_REJECT   = 5'd19;
    localparam logic [PC_W-1:0] A_SHORT    = 5'd20;
    localparam logic [PC_W-1:0] A_MATCH    = 5'd21;

    typedef struct packed {
        logic [3:0]           uop;
        logic [3:0]           cond;
        logic [PC_W-1:0]      target;
        logic [OUTCOME_W-1:0] outcome;
    } ctrl_word_t;

    typedef struct packed {
        logic [3:0]           uop;
        logic [OUTCOME_W-1:0] outcome;
        logic                 accept;
        logic                 fire;
    } dp_ctrl_t;

    typedef struct packed {
        logic op_start;
        logic op_abort;
        logic not_run;
        logic decide;
        logic unm_ok;
        logic att_le1;
        logic out_range;
        logic below_low;
        logic in_win;
        logic more_bins;
    } dp_flags_t;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [BIN_W-1:0]     bin_index;
        logic [DIV_W-1:0]     divisor;
        logic                 engaged;
    } result_t;

    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] addr);
        ctrl_word_t w;
        w = '{uop: UOP_NOP, cond: CND_NEVER, target: A_FETCH, outcome: OC_IGNORED};
        case (addr)
            5'd0:  w = '{UOP_FETCH,          CND_NO_INPUT,  A_FETCH,   OC_IGNORED};
            5'd1:  w = '{UOP_NOP,            CND_OP_START,  A_START,   OC_IGNORED};
            5'd2:  w = '{UOP_NOP,            CND_OP_ABORT,  A_ABORT,   OC_IGNORED};
            5'd3:  w = '{UOP_NOP,            CND_NOT_RUN,   A_IGNORE,  OC_IGNORED};
            5'd4:  w = '{UOP_NOP,            CND_NO_DECIDE, A_VALID,   OC_IGNORED};
            5'd5:  w = '{UOP_NOP,            CND_UNM_OK,    A_SUCCESS, OC_IGNORED};
            5'd6:  w = '{UOP_NOP,            CND_ATT_LE1,   A_FAIL,    OC_IGNORED};
            5'd7:  w = '{UOP_RETRY,          CND_NEVER,     A_FETCH,   OC_IGNORED};
            5'd8:  w = '{UOP_NOP,            CND_OUT_RANGE, A_REJECT,  OC_IGNORED};
            5'd9:  w = '{UOP_INC_TOTAL,      CND_BELOW_LOW, A_SHORT,   OC_IGNORED};
            5'd10: w = '{UOP_LOAD_ACC,       CND_NEVER,     A_FETCH,   OC_IGNORED};
            5'd11: w = '{UOP_NOP,            CND_IN_WIN,    A_MATCH,   OC_IGNORED};
            5'd12: w = '{UOP_STEP_ACC,       CND_MORE_BINS, A_LOOP,    OC_IGNORED};
            5'd13: w = '{UOP_EMIT_UNMATCHED, CND_ALWAYS,    A_FETCH,   OC_UNMATCHED};
            5'd14: w = '{UOP_EMIT_START,     CND_ALWAYS,    A_FETCH,   OC_STARTED};
            5'd15: w = '{UOP_EMIT_ABORT,     CND_ALWAYS,    A_FETCH,   OC_ABORTED};
            5'd16: w = '{UOP_EMIT,           CND_ALWAYS,    A_FETCH,   OC_IGNORED};
            5'd17: w = '{UOP_EMIT_SUCCESS,   CND_ALWAYS,    A_FETCH,   OC_SUCCESS};
            5'd18: w = '{UOP_EMIT_FAIL,      CND_ALWAYS,    A_FETCH,   OC_FAIL};
            5'd19: w = '{UOP_EMIT,           CND_ALWAYS,    A_FETCH,   OC_REJECTED};
            5'd20: w = '{UOP_EMIT_SHORT,     CND_ALWAYS,    A_FETCH,   OC_SHORTEST};
            5'd21: w = '{UOP_EMIT,           CND_ALWAYS,    A_FETCH,   OC_MATCHED};
            default: w = '{UOP_NOP, CND_ALWAYS, A_FETCH, OC_IGNORED};
        endcase
        return w;
    endfunction

endpackage

### design/pwad_in_if.sv
// Input channel interface: opcode and pulse width with valid/ready.
// Depends on pwad_pkg.
`timescale 1ns / 1ps

interface pwad_in_if import pwad_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [PULSE_W-1:0]  pulse_width;

    modport source (output valid, output opcode, output pulse_width, input ready);
    modport sink   (input valid, input opcode, input pulse_width, output ready);
endinterface

### design/pwad_out_if.sv
// Result channel interface: outcome, bin index, divisor, engaged with valid/ready.
// Depends on pwad_pkg.
`timescale 1ns / 1ps

interface pwad_out_if import pwad_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUTCOME_W-1:0] outcome;
    logic [BIN_W-1:0]     bin_index;
    logic [DIV_W-1:0]     divisor;
    logic                 engaged;

    modport source (output valid, output outcome, output bin_index, output divisor,
                    output engaged, input ready);
    modport sink   (input valid, input outcome, input bin_index, input divisor,
                    input engaged, output ready);
endinterface

### design/pwad_datapath.sv
// Datapath of the autobaud detector: config registers, detection state,
// window accumulators and bin counter, driven by micro-ops.
// Depends on pwad_pkg.
`timescale 1ns / 1ps

module pwad_datapath
    import pwad_pkg::*;
#(
    parameter int NUM_BINS   = 20,
    parameter int WIDTH_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic [OPCODE_W-1:0]  opcode,
    input  logic [PULSE_W-1:0]   pulse_width,
    input  dp_ctrl_t             ctrl,
    output dp_flags_t            flags,
    output result_t              result
);

    localparam int W      = WIDTH_BITS;
    localparam int KW     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int BW     = $clog2(NUM_BINS + 1);
    localparam int ACC_W  = W + 1 + BW;
    localparam int CW     = (ACC_W > PULSE_W) ? ACC_W : PULSE_W;
    localparam logic [W-1:0]  WMASK  = {W{1'b1}};
    localparam logic [KW-1:0] K_LAST = KW'(NUM_BINS - 1);

    logic [PULSE_W-1:0]  min_reg, max_reg;
    logic [CNT_W-1:0]    count_lim_reg, unmatch_lim_reg;
    logic [ITER_W-1:0]   iter_lim_reg;

    logic [OPCODE_W-1:0] op_reg;
    logic [PULSE_W-1:0]  pw_reg;

    logic                active_reg, active_next;
    logic [W-1:0]        short_reg;
    logic [W-1:0]        swl_reg;
    logic [W:0]          swh_reg;
    logic [CNT_W-1:0]    total_reg, unm_reg;
    logic [ITER_W-1:0]   att_reg;
    logic [ACC_W-1:0]    lo_reg, hi_reg;
    logic [KW-1:0]       k_reg;

    logic [CW-1:0]       p_ext;
    logic [W-1:0]        w_src;
    logic [W+4:0]        w14, w17;
    logic [W-1:0]        swl_new;
    logic [W:0]          swh_new;
    logic                set_short, clear_cnt, emit_fire;
    logic [KW+BIN_W-1:0] k_ext;
    logic [CW-1:0]       short_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg         <= RST_MIN_WIDTH;
            max_reg         <= RST_MAX_WIDTH;
            count_lim_reg   <= RST_COUNT_LIM;
            unmatch_lim_reg <= RST_UNMATCH_LIM;
            iter_lim_reg    <= RST_ITER_LIM;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_WIDTH:   min_reg         <= cfg_data;
                CFG_MAX_WIDTH:   max_reg         <= cfg_data;
                CFG_COUNT_LIM:   count_lim_reg   <= cfg_data;
                CFG_UNMATCH_LIM: unmatch_lim_reg <= cfg_data;
                CFG_ITER_LIM:    iter_lim_reg    <= cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            op_reg <= opcode;
            pw_reg <= pulse_width;
        end
    end

    assign p_ext     = CW'(pw_reg);
    assign emit_fire = ctrl.fire;

    // shortest-width windows: ~14/16 and ~17/16
    assign w_src   = (ctrl.uop == UOP_EMIT_SHORT) ? p_ext[W-1:0] : WMASK;
    assign w14     = ({5'b0, w_src} << 4) - ({5'b0, w_src} << 1);
    assign w17     = ({5'b0, w_src} << 4) + {5'b0, w_src};
    assign swl_new = (w_src == WMASK) ? WMASK : w14[W+3:4];
    assign swh_new = (w_src == WMASK) ? {1'b0, WMASK} : w17[W+4:4];

    always_comb
    begin
        set_short   = 1'b0;
        clear_cnt   = 1'b0;
        active_next = active_reg;
        unique case (ctrl.uop) inside
            UOP_RETRY:
            begin
                set_short = 1'b1;
                clear_cnt = 1'b1;
            end
            UOP_EMIT_START:
            begin
                set_short   = emit_fire;
                clear_cnt   = emit_fire;
                active_next = 1'b1;
            end
            UOP_EMIT_SHORT:
            begin
                set_short = emit_fire;
                clear_cnt = emit_fire;
            end
            UOP_EMIT_ABORT, UOP_EMIT_SUCCESS, UOP_EMIT_FAIL:
                active_next = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            short_reg  <= WMASK;
            swl_reg    <= WMASK;
            swh_reg    <= {1'b0, WMASK};
            total_reg  <= '0;
            unm_reg    <= '0;
            att_reg    <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            k_reg      <= '0;
        end
        else
        begin
            if (set_short)
            begin
                short_reg <= w_src;
                swl_reg   <= swl_new;
                swh_reg   <= swh_new;
            end
            if (clear_cnt)
            begin
                total_reg <= '0;
                unm_reg   <= '0;
            end
            if (emit_fire)
                active_reg <= active_next;
            case (ctrl.uop)
                UOP_RETRY:
                    att_reg <= att_reg - 1'b1;
                UOP_INC_TOTAL:
                    if (total_reg != CNT_MAX)
                        total_reg <= total_reg + 1'b1;
                UOP_LOAD_ACC:
                begin
                    lo_reg <= ACC_W'(swl_reg);
                    hi_reg <= ACC_W'(swh_reg);
                    k_reg  <= '0;
                end
                UOP_STEP_ACC:
                begin
                    lo_reg <= lo_reg + ACC_W'(swl_reg);
                    hi_reg <= hi_reg + ACC_W'(swh_reg);
                    k_reg  <= k_reg + 1'b1;
                end
                UOP_EMIT_START:
                    if (emit_fire)
                        att_reg <= iter_lim_reg;
                UOP_EMIT_FAIL:
                    if (emit_fire)
                        att_reg <= '0;
                UOP_EMIT_UNMATCHED:
                    if (emit_fire && unm_reg != CNT_MAX)
                        unm_reg <= unm_reg + 1'b1;
                default: ;
            endcase
        end
    end

    assign flags.op_start  = (op_reg == OP_START);
    assign flags.op_abort  = (op_reg == OP_ABORT);
    assign flags.not_run   = (op_reg != OP_PULSE) || !active_reg;
    assign flags.decide    = (total_reg > count_lim_reg);
    assign flags.unm_ok    = (unm_reg <= unmatch_lim_reg);
    assign flags.att_le1   = (att_reg <= ITER_W'(1));
    assign flags.out_range = (pw_reg < min_reg) || (pw_reg > max_reg);
    assign flags.below_low = (p_ext < CW'(swl_reg));
    assign flags.in_win    = (p_ext >= CW'(lo_reg)) && (p_ext <= CW'(hi_reg));
    assign flags.more_bins = (k_reg != K_LAST);

    assign k_ext     = {{BIN_W{1'b0}}, k_reg};
    assign short_ext = CW'(short_reg);

    assign result.outcome   = ctrl.outcome;
    assign result.bin_index = (ctrl.outcome == OC_MATCHED) ? k_ext[BIN_W-1:0] : '0;
    assign result.divisor   = (ctrl.uop == UOP_EMIT_SUCCESS) ? short_ext[DIV_W-1:0] : '0;
    assign result.engaged   = active_next;

endmodule

### design/pulse_width_autobaud_detector.sv
// Pulse width autobaud detector: microcoded sequencer over pwad_datapath.
// One transaction at a time. Start, abort and ignored items emit at once. A pulse past
// the count limit ends in success or fail, or retries; a pulse is range checked, tested
// for a new shortest, then searched bin by bin (bin search loop): matched in bin k or
// unmatched. A held result stalls the emit step; fetch resumes once the result is loaded.
// Asynchronous active-low reset restores register defaults and idle state.
`timescale 1ns / 1ps

module pulse_width_autobaud_detector
    import pwad_pkg::*;
#(
    parameter int NUM_BINS   = 20,
    parameter int WIDTH_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    pwad_in_if.sink              pulse,
    pwad_out_if.source           result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    logic [PC_W-1:0] pc_reg, pc_next;
    ctrl_word_t      cw;
    dp_ctrl_t        dctl;
    dp_flags_t       flags;
    result_t         res;
    result_t         out_reg;
    logic            out_valid_reg;
    logic            is_emit, fire, jump;

    assign cw = ucode_rom(pc_reg);

    always_comb
    begin
        unique case (cw.uop) inside
            UOP_EMIT, UOP_EMIT_START, UOP_EMIT_ABORT, UOP_EMIT_SUCCESS,
            UOP_EMIT_FAIL, UOP_EMIT_SHORT, UOP_EMIT_UNMATCHED: is_emit = 1'b1;
            default: is_emit = 1'b0;
        endcase
    end

    assign fire        = is_emit && (!out_valid_reg || result.ready);
    assign pulse.ready = (cw.uop == UOP_FETCH);

    always_comb
    begin
        unique case (cw.cond)
            CND_NEVER:     jump = 1'b0;
            CND_ALWAYS:    jump = 1'b1;
            CND_NO_INPUT:  jump = !pulse.valid;
            CND_OP_START:  jump = flags.op_start;
            CND_OP_ABORT:  jump = flags.op_abort;
            CND_NOT_RUN:   jump = flags.not_run;
            CND_NO_DECIDE: jump = !flags.decide;
            CND_UNM_OK:    jump = flags.unm_ok;
            CND_ATT_LE1:   jump = flags.att_le1;
            CND_OUT_RANGE: jump = flags.out_range;
            CND_BELOW_LOW: jump = flags.below_low;
            CND_IN_WIN:    jump = flags.in_win;
            CND_MORE_BINS: jump = flags.more_bins;
            default:       jump = 1'b0;
        endcase
    end

    always_comb
    begin
        if (is_emit && !fire)
            pc_next = pc_reg;
        else if (jump)
            pc_next = cw.target;
        else
            pc_next = pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= A_FETCH;
        else
            pc_reg <= pc_next;
    end

    assign dctl.uop     = cw.uop;
    assign dctl.outcome = cw.outcome;
    assign dctl.accept  = pulse.valid && pulse.ready;
    assign dctl.fire    = fire;

    pwad_datapath #(
        .NUM_BINS   (NUM_BINS),
        .WIDTH_BITS (WIDTH_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .opcode      (pulse.opcode),
        .pulse_width (pulse.pulse_width),
        .ctrl        (dctl),
        .flags       (flags),
        .result      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_reg <= res;
    end

    assign result.valid     = out_valid_reg;
    assign result.outcome   = out_reg.outcome;
    assign result.bin_index = out_reg.bin_index;
    assign result.divisor   = out_reg.divisor;
    assign result.engaged   = out_reg.engaged;

endmodule

### bench/tb_pulse_width_autobaud_detector.sv
// Testbench for pulse_width_autobaud_detector: directed script, then random
// phases under several register settings, checked by an in-bench predictor.
// Depends on pwad_pkg, pwad_in_if, pwad_out_if and the detector RTL.
`timescale 1ns / 1ps

module tb_pulse_width_autobaud_detector;
    import pwad_pkg::*;

    localparam int BIN_COUNT = 20;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [OPCODE_W-1:0]  op;
        logic [15:0]          value;
        bit                   typed;
        result_t              want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    pwad_in_if  pulse_ch ();
    pwad_out_if result_ch ();

    pulse_width_autobaud_detector #(
        .NUM_BINS   (BIN_COUNT),
        .WIDTH_BITS (16)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pulse     (pulse_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // register copies
    logic [15:0] lim_min_w     = RST_MIN_WIDTH;
    logic [15:0] lim_max_w     = RST_MAX_WIDTH;
    logic [15:0] lim_count     = RST_COUNT_LIM;
    logic [15:0] lim_unmatched = RST_UNMATCH_LIM;
    logic [7:0]  lim_iter      = RST_ITER_LIM;

    // detector state
    logic        det_active    = 1'b0;
    logic [15:0] det_short     = 16'hFFFF;
    logic [15:0] det_win_lo    = 16'hFFFF;
    logic [16:0] det_win_hi    = 17'h0FFFF;
    logic [15:0] det_total     = '0;
    logic [15:0] det_unmatched = '0;
    logic [7:0]  det_attempts  = '0;

    result_t   awaited_results[$];
    stim_row_t script[$];
    int        mismatch_count = 0;
    int        send_idle = 18;
    int        recv_idle = 51;
    int        rnd_sent = 0;
    int        base_w = 100;

    function automatic void load_shortest(input logic [15:0] w);
        int unsigned wide;
        wide = 32'(w);
        det_short = w;
        if (w == 16'hFFFF)
        begin
            det_win_lo = 16'hFFFF;
            det_win_hi = 17'h0FFFF;
        end
        else
        begin
            det_win_lo = 16'((wide * 14) >> 4);
            det_win_hi = 17'((wide * 17) >> 4);
        end
    endfunction

    function automatic result_t baud_predict(input logic [1:0] op, input logic [15:0] w);
        result_t     r;
        bit          decided;
        bit          found;
        int unsigned lo;
        int unsigned hi;
        r = '0;
        if (op == OP_START)
        begin
            det_total = '0;
            det_unmatched = '0;
            load_shortest(16'hFFFF);
            det_attempts = lim_iter;
            det_active = 1'b1;
            r.outcome = OC_STARTED;
        end
        else if (op == OP_ABORT)
        begin
            det_active = 1'b0;
            r.outcome = OC_ABORTED;
        end
        else if (op != OP_PULSE || !det_active)
            r.outcome = OC_IGNORED;
        else
        begin
            decided = 1'b0;
            if (det_total > lim_count)
            begin
                if (det_unmatched <= lim_unmatched)
                begin
                    det_active = 1'b0;
                    r.outcome = OC_SUCCESS;
                    r.divisor = det_short;
                    decided = 1'b1;
                end
                else if (det_attempts <= 8'd1)
                begin
                    det_attempts = '0;
                    det_active = 1'b0;
                    r.outcome = OC_FAIL;
                    decided = 1'b1;
                end
                else
                begin
                    det_attempts = det_attempts - 8'd1;
                    det_total = '0;
                    det_unmatched = '0;
                    load_shortest(16'hFFFF);
                end
            end
            if (!decided)
            begin
                if (w < lim_min_w || w > lim_max_w)
                    r.outcome = OC_REJECTED;
                else
                begin
                    if (det_total != CNT_MAX)
                        det_total = det_total + 16'd1;
                    if (w < det_win_lo)
                    begin
                        load_shortest(w);
                        det_total = '0;
                        det_unmatched = '0;
                        r.outcome = OC_SHORTEST;
                    end
                    else
                    begin
                        found = 1'b0;
                        lo = 32'(det_win_lo);
                        hi = 32'(det_win_hi);
                        for (int k = 0; k < BIN_COUNT; k++)
                        begin
                            if (!found && w >= lo && w <= hi)
                            begin
                                found = 1'b1;
                                r.outcome = OC_MATCHED;
                                r.bin_index = BIN_W'(k);
                            end
                            lo = lo + 32'(det_win_lo);
                            hi = hi + 32'(det_win_hi);
                        end
                        if (!found)
                        begin
                            r.outcome = OC_UNMATCHED;
                            if (det_unmatched != CNT_MAX)
                                det_unmatched = det_unmatched + 16'd1;
                        end
                    end
                end
            end
        end
        r.engaged = det_active;
        return r;
    endfunction

    function automatic int choose_base();
        int lo_b;
        lo_b = (lim_min_w > 16'd20) ? int'(lim_min_w) : 20;
        if (lo_b > 3000)
            lo_b = 20;
        return $urandom_range(lo_b, 3000);
    endfunction

    function automatic void add_item(input logic [1:0] op, input logic [15:0] value,
                                     input bit typed, input logic [OUTCOME_W-1:0] oc,
                                     input logic [15:0] div, input logic eng);
        stim_row_t row;
        row.is_write = 1'b0;
        row.reg_idx = '0;
        row.op = op;
        row.value = value;
        row.typed = typed;
        row.want = '0;
        row.want.outcome = oc;
        row.want.divisor = div;
        row.want.engaged = eng;
        script.push_back(row);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        stim_row_t row;
        row.is_write = 1'b1;
        row.reg_idx = idx;
        row.op = OP_PULSE;
        row.value = value;
        row.typed = 1'b0;
        row.want = '0;
        script.push_back(row);
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] %s: got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_MIN_WIDTH:   lim_min_w = value;
            CFG_MAX_WIDTH:   lim_max_w = value;
            CFG_COUNT_LIM:   lim_count = value;
            CFG_UNMATCH_LIM: lim_unmatched = value;
            CFG_ITER_LIM:    lim_iter = value[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        pulse_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_item(input logic [1:0] op, input logic [15:0] w,
                             input bit typed, input result_t want);
        result_t predicted;
        while ($urandom_range(0, 99) < send_idle)
        begin
            @(negedge clk);
            pulse_ch.valid <= 1'b0;
        end
        @(negedge clk);
        pulse_ch.valid <= 1'b1;
        pulse_ch.opcode <= op;
        pulse_ch.pulse_width <= w;
        do
            @(posedge clk);
        while (pulse_ch.ready !== 1'b1);
        predicted = baud_predict(op, w);
        awaited_results.push_back(typed ? want : predicted);
    endtask

    task automatic run_phase(input logic [15:0] mn, input logic [15:0] mx,
                             input logic [15:0] cnt, input logic [15:0] unm,
                             input logic [7:0] iters, input int len);
        int          pick;
        int          k;
        int          nom;
        int          w;
        logic [1:0]  op;
        result_t     none;
        none = '0;
        drain_pipeline();
        write_reg(CFG_MIN_WIDTH, mn);
        write_reg(CFG_MAX_WIDTH, mx);
        write_reg(CFG_COUNT_LIM, cnt);
        write_reg(CFG_UNMATCH_LIM, unm);
        write_reg(CFG_ITER_LIM, {8'd0, iters});
        base_w = choose_base();
        for (int n = 0; n < len; n++)
        begin
            if (rnd_sent < 467)
            begin
                send_idle = 18;
                recv_idle = 51;
            end
            else if (rnd_sent < 934)
            begin
                send_idle = 51;
                recv_idle = 18;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            rnd_sent++;
            pick = $urandom_range(0, 99);
            if (!det_active && pick >= 8 && $urandom_range(0, 3) != 0)
                pick = 0;
            op = OP_PULSE;
            w = $urandom_range(0, 65535);
            if (pick < 4)
            begin
                op = OP_START;
                base_w = choose_base();
            end
            else if (pick < 6)
                op = OP_ABORT;
            else if (pick < 8)
                op = OP_UNUSED;
            else if (pick < 16)
                op = OP_PULSE;
            else if (pick < 22)
            begin
                w = base_w - int'($urandom_range(1, base_w / 4 + 1));
                if (w < 0)
                    w = 0;
                if (w > 0 && w >= int'(lim_min_w))
                    base_w = w;
            end
            else
            begin
                k = $urandom_range(1, BIN_COUNT);
                nom = base_w * k;
                w = nom - nom / 16 + int'($urandom_range(0, nom / 8));
                if (w > 65535)
                    w = 65535;
            end
            send_item(op, w[15:0], 1'b0, none);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (awaited_results.size() == 0)
                note_mismatch("transaction with nothing awaited",
                              32'(result_ch.outcome), 0);
            else
            begin
                want = awaited_results.pop_front();
                if (result_ch.outcome !== want.outcome)
                    note_mismatch("outcome", 32'(result_ch.outcome), 32'(want.outcome));
                if (result_ch.bin_index !== want.bin_index)
                    note_mismatch("bin_index", 32'(result_ch.bin_index),
                                  32'(want.bin_index));
                if (result_ch.divisor !== want.divisor)
                    note_mismatch("divisor", 32'(result_ch.divisor), 32'(want.divisor));
                if (result_ch.engaged !== want.engaged)
                    note_mismatch("engaged", 32'(result_ch.engaged), 32'(want.engaged));
            end
        end
    end

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= (rst_n === 1'b1) && ($urandom_range(0, 99) >= recv_idle);
        end
    end

    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pulse_ch.valid = 1'b0;
        pulse_ch.opcode = OP_PULSE;
        pulse_ch.pulse_width = '0;

        add_item(OP_PULSE,  16'd1000,  1'b1, OC_IGNORED,  16'd0, 1'b0);
        add_item(OP_UNUSED, 16'hFFFF,  1'b1, OC_IGNORED,  16'd0, 1'b0);
        add_item(OP_ABORT,  16'd0,     1'b1, OC_ABORTED,  16'd0, 1'b0);
        add_item(OP_START,  16'd0,     1'b1, OC_STARTED,  16'd0, 1'b1);
        add_item(OP_PULSE,  16'd0,     1'b1, OC_REJECTED, 16'd0, 1'b1);
        add_item(OP_PULSE,  16'd52,    1'b1, OC_REJECTED, 16'd0, 1'b1);
        add_item(OP_PULSE,  16'hFFFF,  1'b1, OC_REJECTED, 16'd0, 1'b1);
        add_item(OP_PULSE,  16'd53,    1'b1, OC_SHORTEST, 16'd0, 1'b1);
        add_item(OP_PULSE,  16'd40000, 1'b0, OC_IGNORED,  16'd0, 1'b0);
        add_item(OP_PULSE,  16'd1000,  1'b0, OC_IGNORED,  16'd0, 1'b0);
        add_item(OP_START,  16'd1,     1'b1, OC_STARTED,  16'd0, 1'b1);
        add_item(OP_UNUSED, 16'd0,     1'b1, OC_IGNORED,  16'd0, 1'b1);
        add_item(OP_ABORT,  16'd0,     1'b1, OC_ABORTED,  16'd0, 1'b0);
        add_write(CFG_COUNT_LIM, 16'd1);
        add_write(CFG_UNMATCH_LIM, 16'd0);
        add_write(CFG_ITER_LIM, 16'd2);
        // clean run to success
        add_item(OP_START,  16'd0,     1'b1, OC_STARTED,  16'd0, 1'b1);
        add_item(OP_PULSE,  16'd100,   1'b1, OC_SHORTEST, 16'd0, 1'b1);
        add_item(OP_PULSE,  16'd100,   1'b0, OC_IGNORED,  16'd0, 1'b0);
        add_item(OP_PULSE,  16'd100,   1'b0, OC_IGNORED,  16'd0, 1'b0);
        add_item(OP_PULSE,  16'd100,   1'b1, OC_SUCCESS,  16'd100, 1'b0);
        // one retry, then out of attempts
        add_item(OP_START,  16'd0,     1'b1, OC_STARTED,  16'd0, 1'b1);
        add_item(OP_PULSE,  16'd100,   1'b0, OC_IGNORED,  16'd0, 1'b0);
        add_item(OP_PULSE,  16'd5000,  1'b0, OC_IGNORED,  16'd0, 1'b0);
        add_item(OP_PULSE,  16'd100,   1'b0, OC_IGNORED,  16'd0, 1'b0);
        add_item(OP_PULSE,  16'd100,   1'b0, OC_IGNORED,  16'd0, 1'b0);
        add_item(OP_PULSE,  16'd5000,  1'b0, OC_IGNORED,  16'd0, 1'b0);
        add_item(OP_PULSE,  16'd100,   1'b0, OC_IGNORED,  16'd0, 1'b0);
        add_item(OP_PULSE,  16'd100,   1'b1, OC_FAIL,     16'd0, 1'b0);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].is_write)
            begin
                drain_pipeline();
                write_reg(script[i].reg_idx, script[i].value);
            end
            else
                send_item(script[i].op, script[i].value, script[i].typed, script[i].want);
        end

        run_phase(16'd0,     16'hFFFF,  16'd1,     16'd0,     8'd1,   200);
        run_phase(16'd53,    16'd40000, 16'd20,    16'd3,     8'd3,   300);
        run_phase(16'd100,   16'd5000,  16'd8,     16'hFFFF,  8'd255, 200);
        run_phase(16'hFFFF,  16'd0,     16'hFFFF,  16'd0,     8'd255, 100);
        run_phase(16'd30,    16'd20000, 16'd40,    16'd10,    8'd5,   300);
        run_phase(16'd10,    16'd60000, 16'd12,    16'd2,     8'd2,   300);

        drain_pipeline();
        repeat (60) @(posedge clk);
        if (awaited_results.size() != 0)
            note_mismatch("transactions never returned", awaited_results.size(), 0);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
